/* rtl/core/tccs_pkg.sv */
// Shared constants, types and codes of the text console engine.
package tccs_pkg;

  // Screen geometry and tab spacing
  localparam int COLUMNS  = 80;
  localparam int ROWS     = 25;
  localparam int TAB_STOP = 8;

  localparam int NCELLS = COLUMNS * ROWS;
  localparam int ADDR_W = $clog2(NCELLS);
  localparam int TAB_W  = $clog2(TAB_STOP + 1);

  // Field widths
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int IDX_W  = 11;
  localparam int CELL_W = 16;
  localparam int BYTE_W = 8;
  localparam int NIB_W  = 4;

  // Configuration port
  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;

  // Character codes
  localparam logic [BYTE_W-1:0] CH_BS    = 8'h08;
  localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
  localparam logic [BYTE_W-1:0] CH_NL    = 8'h0a;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0d;
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CH_DEL   = 8'h7f;

  // Colour after reset and the cell the screen is cleared to
  localparam logic [NIB_W-1:0]  RST_FG     = 4'hf;
  localparam logic [NIB_W-1:0]  RST_BG     = 4'h1;
  localparam logic [CELL_W-1:0] CLEAR_CELL = {RST_BG, RST_FG, CH_SPACE};

  typedef enum logic [1:0] {
    KIND_PUT  = 2'd0,
    KIND_READ = 2'd1,
    KIND_FWD  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCROLL_GO,
    ST_SCROLL_WAIT,
    ST_EMIT
  } top_state_t;

  typedef enum logic [1:0] {
    SW_CLEAR,
    SW_IDLE,
    SW_SCROLL
  } scr_state_t;

  typedef enum logic [1:0] {
    SCR_NOP,
    SCR_WRITE,
    SCR_READ,
    SCR_SCROLL
  } scr_op_t;

  typedef struct packed {
    scr_op_t             op;
    logic [ADDR_W-1:0]   addr;
    logic [CELL_W-1:0]   data;
  } scr_cmd_t;

  typedef struct packed {
    logic busy;
  } scr_stat_t;

endpackage

/* rtl/core/tccs_screen.sv */
// Screen store with its sweep sequencer for clearing after reset and scrolling.
module tccs_screen (
  input  logic                         clk,
  input  logic                         rst_n,
  input  tccs_pkg::scr_cmd_t           cmd_i,
  output tccs_pkg::scr_stat_t          stat_o,
  output logic [tccs_pkg::CELL_W-1:0]  rd_data_o
);
  import tccs_pkg::*;

  logic [CELL_W-1:0] mem [NCELLS];
  logic [CELL_W-1:0] rd_data_r;

  scr_state_t        state_r, state_nxt;
  logic [ADDR_W-1:0] cnt_r, cnt_nxt;
  logic [CELL_W-1:0] blank_r;

  // write stage of the sweep
  logic              wr_vld_r, wr_vld_nxt;
  logic              wr_copy_r, wr_copy_nxt;
  logic [ADDR_W-1:0] wr_addr_r;
  logic [CELL_W-1:0] wr_fill_r, wr_fill_nxt;

  logic              cnt_last;
  logic              copy_phase;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [CELL_W-1:0] wdata;

  assign cnt_last   = (cnt_r == ADDR_W'(NCELLS - 1));
  assign copy_phase = (cnt_r < ADDR_W'(NCELLS - COLUMNS));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      SW_CLEAR: begin
        if (cnt_last) state_nxt = SW_IDLE;
      end
      SW_IDLE: begin
        if (cmd_i.op == SCR_SCROLL) state_nxt = SW_SCROLL;
      end
      SW_SCROLL: begin
        if (cnt_last) state_nxt = SW_IDLE;
      end
      default: state_nxt = SW_IDLE;
    endcase
  end

  always_comb begin
    cnt_nxt     = '0;
    wr_vld_nxt  = 1'b0;
    wr_copy_nxt = 1'b0;
    wr_fill_nxt = blank_r;
    rd_en       = 1'b0;
    rd_addr     = cmd_i.addr;
    unique case (state_r)
      SW_CLEAR: begin
        wr_vld_nxt  = 1'b1;
        wr_fill_nxt = CLEAR_CELL;
        cnt_nxt     = cnt_last ? '0 : cnt_r + 1'b1;
      end
      SW_IDLE: begin
        rd_en = (cmd_i.op == SCR_READ);
      end
      SW_SCROLL: begin
        // move each row up one line, then fill the bottom row
        wr_vld_nxt  = 1'b1;
        wr_copy_nxt = copy_phase;
        rd_en       = copy_phase;
        rd_addr     = cnt_r + ADDR_W'(COLUMNS);
        cnt_nxt     = cnt_last ? '0 : cnt_r + 1'b1;
      end
      default: begin
        cnt_nxt = '0;
      end
    endcase
  end

  always_comb begin
    we    = 1'b0;
    waddr = cmd_i.addr;
    wdata = cmd_i.data;
    if (wr_vld_r) begin
      we    = 1'b1;
      waddr = wr_addr_r;
      wdata = wr_copy_r ? rd_data_r : wr_fill_r;
    end else if (cmd_i.op == SCR_WRITE) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= SW_CLEAR;
      cnt_r     <= '0;
      wr_vld_r  <= 1'b0;
      wr_copy_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      wr_vld_r  <= wr_vld_nxt;
      wr_copy_r <= wr_copy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wr_addr_r <= cnt_r;
    wr_fill_r <= wr_fill_nxt;
    if (state_r == SW_IDLE && cmd_i.op == SCR_SCROLL) begin
      blank_r <= cmd_i.data;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign stat_o.busy     = (state_r != SW_IDLE) || wr_vld_r;
  assign rd_data_o       = rd_data_r;

endmodule

/* rtl/core/text_console_cursor_scroll.sv */
// Top level of the text console engine: handshakes, cursor, registers and result staging.
//
//   channel  | direction | handshake           | payload
//   ---------+-----------+---------------------+--------------------------------------------
//   in_      | input     | in_valid / in_ready | req_type, char_code, cell_index
//   out_     | output    | out_valid/out_ready | result_kind, cell_word, out_byte, cursor,
//            |           |                     | bad_index, last
//   config   | input     | APB psel/penable    | fg_color @0x0, bg_color @0x4, forward_mode @0x8
//
// A put, a read or a forwarded byte is accepted in ST_IDLE; ST_EMIT then loads the result
// register. A forwarded delete loads one result per emitted byte, three in all. A put that
// scrolls first passes through ST_SCROLL_GO and ST_SCROLL_WAIT: the screen sweep copies
// one cell a cycle through the single write port of the store. After reset the store is
// cleared one cell a cycle with in_ready low; register writes are taken meanwhile.
// A stalled out_ready holds the result register and, while results remain, the block.
module text_console_cursor_scroll (
  input  logic                         clk,
  input  logic                         rst_n,
  // input channel
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_req_type,
  input  logic [tccs_pkg::BYTE_W-1:0]  in_char_code,
  input  logic [tccs_pkg::IDX_W-1:0]   in_cell_index,
  // result channel
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   out_result_kind,
  output logic [tccs_pkg::CELL_W-1:0]  out_cell_word,
  output logic [tccs_pkg::BYTE_W-1:0]  out_out_byte,
  output logic [tccs_pkg::ROW_W-1:0]   out_cursor_row,
  output logic [tccs_pkg::COL_W-1:0]   out_cursor_col,
  output logic                         out_bad_index,
  output logic                         out_last,
  // configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tccs_pkg::CFG_AW-1:0]  paddr,
  input  logic [tccs_pkg::CFG_DW-1:0]  pwdata,
  output logic [tccs_pkg::CFG_DW-1:0]  prdata,
  output logic                         pready
);
  import tccs_pkg::*;

  localparam logic [1:0] REG_FG  = 2'd0;
  localparam logic [1:0] REG_BG  = 2'd1;
  localparam logic [1:0] REG_FWD = 2'd2;

  localparam logic REQ_PUT  = 1'b0;
  localparam logic REQ_READ = 1'b1;

  // configuration
  logic [NIB_W-1:0] fg_r, bg_r;
  logic             fwd_r;
  logic             cfg_wr;

  // cursor
  logic [ROW_W-1:0] cur_row_r, row_new;
  logic [COL_W-1:0] cur_col_r, col_new;
  logic [TAB_W-1:0] phase_r, phase_new;

  top_state_t state_r, state_nxt;

  // item being answered
  kind_t             pend_kind_r;
  logic [BYTE_W-1:0] pend_byte_r;
  logic              pend_bad_r;
  logic              pend_del_r;
  logic [1:0]        seq_cnt_r;

  // result register
  logic              res_vld_r;
  kind_t             res_kind_r;
  logic [CELL_W-1:0] res_word_r;
  logic [BYTE_W-1:0] res_byte_r;
  logic [ROW_W-1:0]  res_row_r;
  logic [COL_W-1:0]  res_col_r;
  logic              res_bad_r;
  logic              res_last_r;

  scr_cmd_t          scr_cmd;
  scr_stat_t         scr_stat;
  logic [CELL_W-1:0] scr_rdata;

  logic              in_acc;
  logic              put_scr;
  logic              idx_bad;
  logic              is_nl, is_tab, wrap, row_inc, scroll_need;
  logic [COL_W:0]    col_sum;
  logic [ADDR_W-1:0] cur_addr;
  logic [NIB_W*2-1:0] colour;
  logic              out_load;
  logic [CELL_W-1:0] emit_word;
  logic [BYTE_W-1:0] emit_byte;

  tccs_screen u_screen (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_i     (scr_cmd),
    .stat_o    (scr_stat),
    .rd_data_o (scr_rdata)
  );

  // ---------------------------------------------------------------- configuration
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    prdata = '0;
    unique case (paddr[3:2])
      REG_FG:  prdata = CFG_DW'(fg_r);
      REG_BG:  prdata = CFG_DW'(bg_r);
      REG_FWD: prdata = CFG_DW'(fwd_r);
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fg_r  <= RST_FG;
      bg_r  <= RST_BG;
      fwd_r <= 1'b0;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_FG:  fg_r  <= pwdata[NIB_W-1:0];
        REG_BG:  bg_r  <= pwdata[NIB_W-1:0];
        REG_FWD: fwd_r <= pwdata[0];
        default: ;
      endcase
    end
  end

  assign colour = {bg_r, fg_r};

  // ---------------------------------------------------------------- cursor step
  // The column never rests at or past COLUMNS, so one wrap check settles it.
  assign in_ready = (state_r == ST_IDLE) && !scr_stat.busy;
  assign in_acc   = in_valid && in_ready;
  assign put_scr  = in_acc && (in_req_type == REQ_PUT) && !fwd_r;
  assign idx_bad  = (32'(in_cell_index) >= 32'(NCELLS));

  assign is_nl  = (in_char_code == CH_NL);
  assign is_tab = (in_char_code == CH_TAB);

  always_comb begin
    if (is_nl) begin
      col_sum = '0;
    end else if (is_tab) begin
      // advance to the next tab stop: add what is left of the current stop
      col_sum = {1'b0, cur_col_r} + (COL_W + 1)'(TAB_STOP) - (COL_W + 1)'(phase_r);
    end else begin
      col_sum = {1'b0, cur_col_r} + 1'b1;
    end
  end

  assign wrap        = (col_sum >= (COL_W + 1)'(COLUMNS));
  assign row_inc     = is_nl || wrap;
  assign scroll_need = row_inc && (cur_row_r == ROW_W'(ROWS - 1));
  assign col_new     = wrap ? '0 : col_sum[COL_W-1:0];
  assign row_new     = (row_inc && !scroll_need) ? cur_row_r + 1'b1 : cur_row_r;

  always_comb begin
    if (is_nl || is_tab || wrap) begin
      phase_new = '0;
    end else if (phase_r == TAB_W'(TAB_STOP - 1)) begin
      phase_new = '0;
    end else begin
      phase_new = phase_r + 1'b1;
    end
  end

  assign cur_addr = ADDR_W'(cur_row_r) * ADDR_W'(COLUMNS) + ADDR_W'(cur_col_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_row_r <= '0;
      cur_col_r <= '0;
      phase_r   <= '0;
    end else if (put_scr) begin
      cur_row_r <= row_new;
      cur_col_r <= col_new;
      phase_r   <= phase_new;
    end
  end

  // ---------------------------------------------------------------- sequencer
  assign out_load = (state_r == ST_EMIT) && (!res_vld_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = (put_scr && scroll_need) ? ST_SCROLL_GO : ST_EMIT;
        end
      end
      ST_SCROLL_GO:   state_nxt = ST_SCROLL_WAIT;
      ST_SCROLL_WAIT: begin
        if (!scr_stat.busy) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_load && seq_cnt_r == 2'd0) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // screen commands: cell write or read at accept, scroll from ST_SCROLL_GO
  always_comb begin
    scr_cmd.op   = SCR_NOP;
    scr_cmd.addr = cur_addr;
    scr_cmd.data = {colour, in_char_code};
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && in_req_type == REQ_READ && !idx_bad) begin
          scr_cmd.op   = SCR_READ;
          scr_cmd.addr = ADDR_W'(in_cell_index);
        end else if (put_scr && !is_nl && !is_tab) begin
          scr_cmd.op = SCR_WRITE;
        end
      end
      ST_SCROLL_GO: begin
        scr_cmd.op   = SCR_SCROLL;
        scr_cmd.data = {colour, CH_SPACE};
      end
      default: scr_cmd.op = SCR_NOP;
    endcase
  end

  // capture what the answer needs at accept
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_cnt_r <= 2'd0;
    end else if (in_acc) begin
      seq_cnt_r <= (in_req_type == REQ_PUT && fwd_r && in_char_code == CH_DEL) ? 2'd2 : 2'd0;
    end else if (out_load && seq_cnt_r != 2'd0) begin
      seq_cnt_r <= seq_cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      if (in_req_type == REQ_READ) begin
        pend_kind_r <= KIND_READ;
      end else if (fwd_r) begin
        pend_kind_r <= KIND_FWD;
      end else begin
        pend_kind_r <= KIND_PUT;
      end
      pend_byte_r <= (in_char_code == CH_CR) ? CH_NL : in_char_code;
      pend_del_r  <= (in_char_code == CH_DEL);
      pend_bad_r  <= (in_req_type == REQ_READ) && idx_bad;
    end
  end

  // ---------------------------------------------------------------- result register
  always_comb begin
    emit_word = '0;
    emit_byte = '0;
    case (pend_kind_r)
      KIND_READ: emit_word = pend_bad_r ? '0 : scr_rdata;
      KIND_FWD: begin
        if (!pend_del_r) begin
          emit_byte = pend_byte_r;
        end else begin
          // delete goes out as backspace, space, backspace
          emit_byte = (seq_cnt_r == 2'd1) ? CH_SPACE : CH_BS;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_vld_r <= 1'b0;
    end else if (out_load) begin
      res_vld_r <= 1'b1;
    end else if (out_ready) begin
      res_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      res_kind_r <= pend_kind_r;
      res_word_r <= emit_word;
      res_byte_r <= emit_byte;
      res_row_r  <= cur_row_r;
      res_col_r  <= cur_col_r;
      res_bad_r  <= pend_bad_r;
      res_last_r <= (seq_cnt_r == 2'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign out_valid       = res_vld_r;
  assign out_result_kind = res_kind_r;
  assign out_cell_word   = res_word_r;
  assign out_out_byte    = res_byte_r;
  assign out_cursor_row  = res_row_r;
  assign out_cursor_col  = res_col_r;
  assign out_bad_index   = res_bad_r;
  assign out_last        = res_last_r;

endmodule

/* tb/tccs_tb_pkg.sv */
// Request and register codes shared by the console testbench files.
package tccs_tb_pkg;

  typedef enum logic {
    REQ_PUT  = 1'b0,
    REQ_READ = 1'b1
  } req_t;

  // Register index; the byte address is four times this value
  typedef enum logic [1:0] {
    REG_FG  = 2'd0,
    REG_BG  = 2'd1,
    REG_FWD = 2'd2
  } cfg_reg_t;

endpackage

/* tb/console_result_checker.sv */
// Checker that mirrors the console state, predicts every result and compares it.
module console_result_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  logic                         in_req_type,
  input  logic [tccs_pkg::BYTE_W-1:0]  in_char_code,
  input  logic [tccs_pkg::IDX_W-1:0]   in_cell_index,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  logic [1:0]                   out_result_kind,
  input  logic [tccs_pkg::CELL_W-1:0]  out_cell_word,
  input  logic [tccs_pkg::BYTE_W-1:0]  out_out_byte,
  input  logic [tccs_pkg::ROW_W-1:0]   out_cursor_row,
  input  logic [tccs_pkg::COL_W-1:0]   out_cursor_col,
  input  logic                         out_bad_index,
  input  logic                         out_last,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tccs_pkg::CFG_AW-1:0]  paddr,
  input  logic [tccs_pkg::CFG_DW-1:0]  pwdata,
  input  logic                         pready,
  output int                           fail_count,
  output int                           pending,
  output int                           results_checked,
  output int                           scrolls
);
  import tccs_pkg::*;
  import tccs_tb_pkg::*;

  typedef struct packed {
    kind_t               kind;
    logic [CELL_W-1:0]   word;
    logic [BYTE_W-1:0]   fwd_byte;
    logic [ROW_W-1:0]    row;
    logic [COL_W-1:0]    col;
    logic                bad;
    logic                last;
  } console_result_t;

  // Mirror of the block's state and registers
  logic [CELL_W-1:0] screen [NCELLS];
  int                cur_col;
  int                cur_row;
  logic [NIB_W-1:0]  fg_nib;
  logic [NIB_W-1:0]  bg_nib;
  logic              fwd_on;

  console_result_t   awaited_results [$];

  function automatic logic [CELL_W-1:0] coloured_cell(logic [BYTE_W-1:0] ch);
    return {bg_nib, fg_nib, ch};
  endfunction

  function automatic void owe_result(kind_t kind, logic [CELL_W-1:0] word,
                                     logic [BYTE_W-1:0] fwd_byte, logic bad, logic last);
    console_result_t r;
    r.kind     = kind;
    r.word     = word;
    r.fwd_byte = fwd_byte;
    r.row      = ROW_W'(cur_row);
    r.col      = COL_W'(cur_col);
    r.bad      = bad;
    r.last     = last;
    awaited_results.push_back(r);
  endfunction

  function automatic void scroll_screen();
    for (int i = 0; i < NCELLS - COLUMNS; i++) screen[i] = screen[i + COLUMNS];
    for (int i = NCELLS - COLUMNS; i < NCELLS; i++) screen[i] = coloured_cell(CH_SPACE);
    scrolls++;
  endfunction

  function automatic void draw_char(logic [BYTE_W-1:0] ch);
    if (ch == CH_NL) begin
      cur_col = 0;
      cur_row++;
    end else if (ch == CH_TAB) begin
      cur_col = (cur_col + TAB_STOP) / TAB_STOP * TAB_STOP;
    end else begin
      if (cur_row < ROWS && cur_col < COLUMNS) screen[cur_row * COLUMNS + cur_col] = coloured_cell(ch);
      cur_col++;
    end
    if (cur_col >= COLUMNS) begin
      cur_col = 0;
      cur_row++;
    end
    if (cur_row >= ROWS) begin
      scroll_screen();
      cur_row = ROWS - 1;
    end
  endfunction

  function automatic void predict_console(logic req, logic [BYTE_W-1:0] ch,
                                          logic [IDX_W-1:0] idx);
    if (req == REQ_READ) begin
      if (int'(idx) < NCELLS) owe_result(KIND_READ, screen[idx], '0, 1'b0, 1'b1);
      else owe_result(KIND_READ, '0, '0, 1'b1, 1'b1);
    end else if (fwd_on) begin
      if (ch == CH_DEL) begin
        owe_result(KIND_FWD, '0, CH_BS, 1'b0, 1'b0);
        owe_result(KIND_FWD, '0, CH_SPACE, 1'b0, 1'b0);
        owe_result(KIND_FWD, '0, CH_BS, 1'b0, 1'b1);
      end else if (ch == CH_CR) begin
        owe_result(KIND_FWD, '0, CH_NL, 1'b0, 1'b1);
      end else begin
        owe_result(KIND_FWD, '0, ch, 1'b0, 1'b1);
      end
    end else begin
      draw_char(ch);
      owe_result(KIND_PUT, '0, '0, 1'b0, 1'b1);
    end
  endfunction

  task automatic compare_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      fail_count++;
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    console_result_t want;
    if (!rst_n) begin
      for (int i = 0; i < NCELLS; i++) screen[i] = CLEAR_CELL;
      cur_col = 0;
      cur_row = 0;
      fg_nib  = RST_FG;
      bg_nib  = RST_BG;
      fwd_on  = 1'b0;
      awaited_results.delete();
      fail_count      = 0;
      pending         = 0;
      results_checked = 0;
      scrolls         = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_FG:  fg_nib = pwdata[NIB_W-1:0];
          REG_BG:  bg_nib = pwdata[NIB_W-1:0];
          REG_FWD: fwd_on = pwdata[0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) predict_console(in_req_type, in_char_code, in_cell_index);
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result, expected none, got kind %0d word 0x%0h byte 0x%0h",
                   $time, out_result_kind, out_cell_word, out_out_byte);
        end else begin
          want = awaited_results.pop_front();
          compare_field("result_kind", want.kind, out_result_kind);
          compare_field("cell_word", want.word, out_cell_word);
          compare_field("out_byte", want.fwd_byte, out_out_byte);
          compare_field("cursor_row", want.row, out_cursor_row);
          compare_field("cursor_col", want.col, out_cursor_col);
          compare_field("bad_index", want.bad, out_bad_index);
          compare_field("last", want.last, out_last);
          results_checked++;
        end
      end
      pending = awaited_results.size();
    end
  end

endmodule

/* tb/text_console_cursor_scroll_tb.sv */
// Testbench top for the text console engine: stimulus, flow control and verdict.
module text_console_cursor_scroll_tb;
  import tccs_pkg::*;
  import tccs_tb_pkg::*;

  // Five random phases of 86 requests plus about two dozen directed ones
  localparam int RANDOM_PHASES    = 5;
  localparam int ITEMS_PER_PHASE  = 86;
  localparam int LONG_HOLD_CYCLES = 400;
  // Let stray results show up after the drain
  localparam int SETTLE_CYCLES    = 20;
  // Worst case: every put scrolls on ~460 requests, plus the clearing sweep, three results
  // each waiting out the longest receiver stall, and the longest sender gaps.
  // The limit allows about three times that total.
  localparam int CYCLE_LIMIT      = 3_000_000;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic                 in_req_type;
  logic [BYTE_W-1:0]    in_char_code;
  logic [IDX_W-1:0]     in_cell_index;
  logic                 out_valid;
  logic                 out_ready;
  logic [1:0]           out_result_kind;
  logic [CELL_W-1:0]    out_cell_word;
  logic [BYTE_W-1:0]    out_out_byte;
  logic [ROW_W-1:0]     out_cursor_row;
  logic [COL_W-1:0]     out_cursor_col;
  logic                 out_bad_index;
  logic                 out_last;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [CFG_AW-1:0]    paddr;
  logic [CFG_DW-1:0]    pwdata;
  logic [CFG_DW-1:0]    prdata;
  logic                 pready;

  int                   fail_count;
  int                   pending;
  int                   results_checked;
  int                   scrolls;

  // calm: no idling on either side; hold_off_req: ask the receiver for one long stall
  bit                   calm;
  bit                   hold_off_req;
  int                   items_sent;
  int unsigned          cycle_count;

  text_console_cursor_scroll dut (.*);

  console_result_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run watchdog: count every clock and stop the run if it never finishes
  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    cycle_count = 0;
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Timeout after %0d cycles with %0d results outstanding", cycle_count, pending);
    $display("FAIL");
    $finish;
  end

  // Mostly short idle stretches, now and then a long one
  function automatic int idle_span();
    return ($urandom_range(9) < 8) ? $urandom_range(3, 1) : $urandom_range(40, 12);
  endfunction

  // Receiver: stall out_ready at random; honor one long hold-off counted here
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(negedge clk);
      end else if (calm || $urandom_range(99) < 70) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b0;
        repeat (idle_span() - 1) @(negedge clk);
      end
    end
  end

  // Offer one request and hold it until the transaction completes, then maybe idle.
  // A zero gap keeps in_valid high straight into the next request.
  task automatic offer(logic req, logic [BYTE_W-1:0] ch, logic [IDX_W-1:0] idx);
    int gap;
    @(negedge clk);
    in_valid      <= 1'b1;
    in_req_type   <= req;
    in_char_code  <= ch;
    in_cell_index <= idx;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    gap = (calm || $urandom_range(99) < 55) ? 0 : idle_span();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Unused fields carry noise so every input bit toggles
  task automatic put_char(logic [BYTE_W-1:0] ch);
    offer(REQ_PUT, ch, IDX_W'($urandom_range(2047)));
  endtask

  task automatic read_cell(int idx);
    offer(REQ_READ, BYTE_W'($urandom_range(255)), IDX_W'(idx));
  endtask

  // Drop valid and wait until every predicted result has been taken
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // APB write: setup cycle, then access cycle; upper data bits are noise the block masks
  task automatic cfg_write(cfg_reg_t r, logic [NIB_W-1:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= {28'($urandom()), val};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin : stimulus
    logic [NIB_W-1:0]  fg_v;
    logic [NIB_W-1:0]  bg_v;
    logic              fwd_v;
    logic [BYTE_W-1:0] ch_v;
    int                roll;

    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_req_type   = REQ_PUT;
    in_char_code  = '0;
    in_cell_index = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    calm          = 1'b0;
    hold_off_req  = 1'b0;
    items_sent    = 0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // Reset colours: the cleared screen, edges of the index range, every put flavor.
    // The block sweeps the store after reset, so the first transaction waits on in_ready.
    read_cell(0);
    read_cell(NCELLS - 1);
    read_cell(NCELLS);
    read_cell(2047);
    put_char(8'h41);
    put_char(8'hff);
    put_char(8'h00);
    put_char(CH_TAB);
    put_char(CH_CR);
    put_char(CH_DEL);
    put_char(CH_NL);
    read_cell(1);
    read_cell(8);
    read_cell(9);
    read_cell(10);

    // Forward mode with extreme colours: delete expands, carriage return maps to newline
    drain();
    cfg_write(REG_FG, 4'h0);
    cfg_write(REG_BG, 4'hf);
    cfg_write(REG_FWD, 4'h1);
    put_char(CH_DEL);
    put_char(CH_CR);
    put_char(CH_NL);
    put_char(8'h80);
    put_char(8'h7e);
    read_cell(0);

    // Back to drawing: the new colour lands only on freshly written cells
    drain();
    cfg_write(REG_FWD, 4'h0);
    put_char(8'h78);
    read_cell(COLUMNS);
    read_cell(0);

    // Random phases, each with its own register setting
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      drain();
      fg_v  = NIB_W'($urandom());
      bg_v  = NIB_W'($urandom());
      fwd_v = 1'b0;
      calm  = 1'b0;
      case (p)
        0: begin
          fg_v = 4'hf;
          bg_v = 4'hf;
          calm = 1'b1;
        end
        1: begin
          fg_v = 4'h0;
          bg_v = 4'h0;
          calm = 1'b1;
        end
        2: fwd_v = 1'b1;
        default: ;
      endcase
      cfg_write(REG_FG, fg_v);
      cfg_write(REG_BG, bg_v);
      cfg_write(REG_FWD, NIB_W'(fwd_v));
      // Stall the receiver for a long stretch while requests keep coming, so the block fills
      if (p == 1) hold_off_req = 1'b1;

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (p == 1 && n == 30) calm = 1'b0;
        // Pause mid-phase until the pipeline is empty, then resume
        if (p == 3 && n == ITEMS_PER_PHASE / 2) drain();
        roll = $urandom_range(99);
        if (roll < 35) begin
          // Mostly reads inside the screen, some past its end
          if ($urandom_range(99) < 85) read_cell($urandom_range(NCELLS - 1));
          else read_cell($urandom_range(2047, NCELLS));
        end else begin
          // Heavy on control characters so wraps and scrolls come often
          roll = $urandom_range(99);
          if (roll < 20)      ch_v = CH_NL;
          else if (roll < 30) ch_v = CH_TAB;
          else if (roll < 36) ch_v = CH_DEL;
          else if (roll < 42) ch_v = CH_CR;
          else                ch_v = BYTE_W'($urandom_range(255));
          put_char(ch_v);
        end
      end
    end

    // Let everything drain, then give stray results a chance to show up
    drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
    $display("Sent %0d requests over %0d register settings, drawing and forwarding both.",
             items_sent, RANDOM_PHASES + 3);
    $display("Checked %0d results; the screen scrolled %0d times.", results_checked, scrolls);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
